>>> rtl/key_value_table_defines.svh
// Assertion macros shared by the key-value table modules.
// KVT_ASSERT expects clk_i and rst_ni, KVT_ASSERT_ALWAYS only clk_i, to be visible in the using module.
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define KVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define KVT_ASSERT(lbl, prop, msg)
`define KVT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/kvt_pkg.sv
package kvt_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  // One entry of the key store; the valid mark lives beside the key.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
  } slot_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } status_t;

endpackage

>>> rtl/key_value_table.sv
// A request taken at a start edge scans the key memory's single read port, one slot per
// cycle, stopping at the first matching key or after the last slot; then ST_WRITE does the
// write-back and done_o is strobed. A new request is taken only after that write-back.
// Reset: asynchronous, active low; afterwards busy stays high while a sweep clears every
// valid mark. absent_value resets to 0. Results cannot be stalled.
`include "key_value_table_defines.svh"

module key_value_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode_i,
  input  logic signed [kvt_pkg::KeyW-1:0] key_i,
  input  logic signed [kvt_pkg::ValW-1:0] value_i,
  input  logic                            absent_value_we_i,
  input  logic signed [kvt_pkg::ValW-1:0] absent_value_i,
  output logic                            done_o,
  output logic signed [kvt_pkg::ValW-1:0] result_value_o,
  output logic                            found_o,
  output logic                            table_full_o,
  output logic [kvt_pkg::CountW-1:0]      pair_count_o,
  output logic                            is_empty_o
);

  kvt_pkg::cmd_t    cmd;
  kvt_pkg::status_t status;

  kvt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  kvt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .absent_value_we_i (absent_value_we_i),
    .absent_value_i    (absent_value_i),
    .mode_i            (mode_i),
    .key_i             (key_i),
    .value_i           (value_i),
    .result_value_o    (result_value_o),
    .found_o           (found_o),
    .table_full_o      (table_full_o),
    .pair_count_o      (pair_count_o),
    .is_empty_o        (is_empty_o),
    .done_o            (done_o)
  );

  // Each accepted word yields exactly one strobe, never back to back.
  `KVT_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held for two cycles")
  `KVT_ASSERT(a_no_done_while_idle_start, (start && !busy) |=> !done_o,
              "result strobe right after accepting a word")

endmodule

>>> rtl/kvt_ctrl.sv
`include "key_value_table_defines.svh"

module kvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  kvt_pkg::status_t  status_i,
  output kvt_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load  = (state_q == ST_IDLE) && start_i;
    cmd_o.clear = (state_q == ST_CLEAR);
    cmd_o.scan  = (state_q == ST_SCAN);
    cmd_o.write = (state_q == ST_WRITE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

  `KVT_ASSERT(a_busy_tracks_state, busy_q == (state_q != ST_IDLE), "busy out of step with state")
  `KVT_ASSERT(a_write_single_cycle, (state_q == ST_WRITE) |=> (state_q == ST_IDLE),
              "write-back lasted more than one cycle")

endmodule

>>> rtl/kvt_dp.sv
`include "key_value_table_defines.svh"

module kvt_dp #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kvt_pkg::cmd_t                 cmd_i,
  output kvt_pkg::status_t              status_o,
  input  logic                          absent_value_we_i,
  input  logic signed [kvt_pkg::ValW-1:0] absent_value_i,
  input  logic [1:0]                    mode_i,
  input  logic signed [kvt_pkg::KeyW-1:0] key_i,
  input  logic signed [kvt_pkg::ValW-1:0] value_i,
  output logic signed [kvt_pkg::ValW-1:0] result_value_o,
  output logic                          found_o,
  output logic                          table_full_o,
  output logic [kvt_pkg::CountW-1:0]    pair_count_o,
  output logic                          is_empty_o,
  output logic                          done_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LastAddr = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FullCount = CW'(ENTRIES);

  kvt_pkg::slot_t         kmem [ENTRIES];
  logic [kvt_pkg::ValW-1:0] vmem [ENTRIES];

  kvt_pkg::slot_t           rd_slot_q;
  logic [kvt_pkg::ValW-1:0] rd_val_q;

  logic [AW-1:0]            addr_q, cmp_addr_q;
  logic                     issuing_q, cmp_valid_q;
  logic [1:0]               mode_q;
  logic [kvt_pkg::KeyW-1:0] key_q;
  logic [kvt_pkg::ValW-1:0] value_q;
  logic [kvt_pkg::ValW-1:0] absent_q;

  logic                     hit_q, free_found_q;
  logic [AW-1:0]            hit_addr_q, free_addr_q;
  logic [kvt_pkg::ValW-1:0] hit_val_q;

  logic [CW-1:0]            count_q, count_d;

  logic [kvt_pkg::ValW-1:0] res_q, res_d;
  logic                     found_q, full_q, full_d, empty_q, done_q;
  logic [kvt_pkg::CountW-1:0] pair_count_q;

  logic                     cmp_en, match;
  logic                     kw_en, vw_en;
  logic [AW-1:0]            kw_addr, vw_addr;
  kvt_pkg::slot_t           kw_data;

  // A slot read is issued one cycle and compared the next.
  assign cmp_en = cmd_i.scan && cmp_valid_q;
  assign match  = cmp_en && rd_slot_q.valid && (rd_slot_q.key == key_q);

  assign status_o.scan_done  = cmp_en && (match || (cmp_addr_q == LastAddr));
  assign status_o.clear_done = cmd_i.clear && (addr_q == LastAddr);

  always_comb begin
    kw_en   = 1'b0;
    kw_addr = addr_q;
    kw_data = '0;
    vw_en   = 1'b0;
    vw_addr = hit_addr_q;
    count_d = count_q;
    res_d   = absent_q;
    full_d  = 1'b0;
    if (cmd_i.clear) begin
      kw_en = 1'b1;
    end else if (cmd_i.write) begin
      if (hit_q) begin
        res_d = hit_val_q;
        case (mode_q)
          kvt_pkg::MODE_ADD: begin
            vw_en = 1'b1;
          end
          kvt_pkg::MODE_REMOVE: begin
            kw_en         = 1'b1;
            kw_addr       = hit_addr_q;
            kw_data.valid = 1'b0;
            kw_data.key   = key_q;
            if (count_q != '0) count_d = count_q - 1'b1;
          end
          default: begin
          end
        endcase
      end else if (mode_q == kvt_pkg::MODE_ADD) begin
        if (free_found_q) begin
          kw_en         = 1'b1;
          kw_addr       = free_addr_q;
          kw_data.valid = 1'b1;
          kw_data.key   = key_q;
          vw_en         = 1'b1;
          vw_addr       = free_addr_q;
          count_d       = count_q + 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
    end
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (kw_en) kmem[kw_addr] <= kw_data;
    if (vw_en) vmem[vw_addr] <= value_q;
    rd_slot_q <= kmem[addr_q];
    rd_val_q  <= vmem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (match) begin
      hit_addr_q <= cmp_addr_q;
      hit_val_q  <= rd_val_q;
    end
    if (cmp_en && !rd_slot_q.valid && !free_found_q) free_addr_q <= cmp_addr_q;
    if (cmd_i.scan) cmp_addr_q <= addr_q;
    if (cmd_i.write) begin
      res_q        <= res_d;
      found_q      <= hit_q;
      full_q       <= full_d;
      pair_count_q <= kvt_pkg::CountW'(count_d);
      empty_q      <= (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issuing_q    <= 1'b0;
      cmp_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      count_q      <= '0;
      absent_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      if (absent_value_we_i) absent_q <= absent_value_i;
      done_q  <= cmd_i.write;
      count_q <= count_d;
      if (cmd_i.load) begin
        addr_q       <= '0;
        issuing_q    <= 1'b1;
        cmp_valid_q  <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.clear) begin
        if (addr_q != LastAddr) addr_q <= addr_q + 1'b1;
      end else if (cmd_i.scan) begin
        cmp_valid_q <= issuing_q;
        if (issuing_q) begin
          if (addr_q == LastAddr) begin
            issuing_q <= 1'b0;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        if (match) hit_q <= 1'b1;
        if (cmp_en && !rd_slot_q.valid) free_found_q <= 1'b1;
      end
    end
  end

  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign table_full_o   = full_q;
  assign pair_count_o   = pair_count_q;
  assign is_empty_o     = empty_q;
  assign done_o         = done_q;

  `KVT_ASSERT(a_count_bounded, count_q <= FullCount, "pair count above capacity")
  `KVT_ASSERT(a_full_only_when_full, (done_q && full_q) |-> (count_q == FullCount && !found_q),
              "refused add while the table had room")
  `KVT_ASSERT(a_empty_matches_count, (done_q && empty_q) |-> (count_q == '0),
              "empty flag reported with stored pairs")

endmodule

>>> tb/key_value_table_tb.sv
`timescale 1ns / 1ps

module key_value_table_tb;

  localparam int unsigned ENTRIES = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES = ENTRIES + 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
    int unsigned gap;
  } step_t;

  typedef struct {
    logic [31:0]                value;
    logic                       found;
    logic                       full;
    logic [kvt_pkg::CountW-1:0] count;
    logic                       empty;
  } reply_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        mode_i = 2'd0;
  logic signed [kvt_pkg::KeyW-1:0]   key_i = '0;
  logic signed [kvt_pkg::ValW-1:0]   value_i = '0;
  logic                              absent_value_we_i = 1'b0;
  logic signed [kvt_pkg::ValW-1:0]   absent_value_i = '0;
  logic                              done_o;
  logic signed [kvt_pkg::ValW-1:0]   result_value_o;
  logic                              found_o;
  logic                              table_full_o;
  logic [kvt_pkg::CountW-1:0]        pair_count_o;
  logic                              is_empty_o;

  key_value_table #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .absent_value_we_i(absent_value_we_i),
    .absent_value_i   (absent_value_i),
    .done_o           (done_o),
    .result_value_o   (result_value_o),
    .found_o          (found_o),
    .table_full_o     (table_full_o),
    .pair_count_o     (pair_count_o),
    .is_empty_o       (is_empty_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the table contents.
  logic [31:0] model_keys [ENTRIES];
  logic [31:0] model_vals [ENTRIES];
  bit          model_used [ENTRIES];
  int unsigned model_count = 0;
  logic [31:0] model_absent = 32'd0;

  step_t       pending[$];
  reply_t      expected_replies[$];
  step_t       cur_req;
  step_t       cfg_step;
  reply_t      want;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  bit          no_gaps = 1'b0;

  logic        nxt_start;
  logic        nxt_we;
  logic [1:0]  nxt_mode;
  logic [31:0] nxt_key;
  logic [31:0] nxt_val;
  logic [31:0] nxt_abs;

  function automatic reply_t apply_request(logic [1:0] md, logic [31:0] k, logic [31:0] v);
    reply_t r;
    int     hit;
    int     slot;
    hit = -1;
    slot = -1;
    r.value = model_absent;
    r.found = 1'b0;
    r.full = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && model_used[i] && model_keys[i] == k) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      r.value = model_vals[hit];
      if (md == kvt_pkg::MODE_ADD) begin
        model_vals[hit] = v;
      end else if (md == kvt_pkg::MODE_REMOVE) begin
        model_used[hit] = 1'b0;
        model_count--;
      end
    end else if (md == kvt_pkg::MODE_ADD) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !model_used[i]) slot = i;
      end
      if (slot >= 0) begin
        model_keys[slot] = k;
        model_vals[slot] = v;
        model_used[slot] = 1'b1;
        model_count++;
      end else begin
        r.full = 1'b1;
      end
    end
    r.count = model_count[kvt_pkg::CountW-1:0];
    r.empty = (model_count == 0);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return kvt_pkg::MODE_ADD;
    if (r < 67) return kvt_pkg::MODE_SEARCH;
    if (r < 94) return kvt_pkg::MODE_REMOVE;
    return MODE_UNUSED;
  endfunction

  task automatic push_req(logic [1:0] md, logic [31:0] k, logic [31:0] v);
    pending.push_back('{kind: STEP_REQ, mode: md, key: k, value: v, gap: pick_gap()});
  endtask

  task automatic push_cfg(logic [31:0] v);
    pending.push_back('{kind: STEP_CFG, mode: 2'd0, key: 32'd0, value: v, gap: 0});
  endtask

  task automatic push_drain();
    pending.push_back('{kind: STEP_DRAIN, mode: 2'd0, key: 32'd0, value: 32'd0, gap: 0});
  endtask

  task automatic report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want_v, got_v);
  endtask

  // Driver. The expected reply of a request word is computed at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      mode_i <= 2'd0;
      key_i <= '0;
      value_i <= '0;
      absent_value_we_i <= 1'b0;
      absent_value_i <= '0;
      gap_left = 0;
      quiet_cycles = 0;
    end else begin
      nxt_start = start;
      nxt_mode = mode_i;
      nxt_key = key_i;
      nxt_val = value_i;
      nxt_we = 1'b0;
      nxt_abs = absent_value_i;
      if (start && !busy) begin
        expected_replies.push_back(apply_request(cur_req.mode, cur_req.key, cur_req.value));
        nxt_start = 1'b0;
        gap_left = cur_req.gap;
      end
      if (expected_replies.size() == 0 && !busy && !start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          case (pending[0].kind)
            STEP_REQ: begin
              cur_req = pending.pop_front();
              nxt_start = 1'b1;
              nxt_mode = cur_req.mode;
              nxt_key = cur_req.key;
              nxt_val = cur_req.value;
            end
            STEP_CFG: begin
              // The register is only touched once the block has gone quiet.
              if (quiet_cycles >= 4) begin
                cfg_step = pending.pop_front();
                nxt_we = 1'b1;
                nxt_abs = cfg_step.value;
                model_absent = cfg_step.value;
                quiet_cycles = 0;
              end
            end
            default: begin
              if (quiet_cycles >= 1) void'(pending.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      mode_i <= nxt_mode;
      key_i <= nxt_key;
      value_i <= nxt_val;
      absent_value_we_i <= nxt_we;
      absent_value_i <= nxt_abs;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result with nothing expected", 32'd0, result_value_o);
      end else begin
        want = expected_replies.pop_front();
        if (result_value_o !== want.value)
          report_mismatch("result_value", want.value, result_value_o);
        if (found_o !== want.found) report_mismatch("found", want.found, found_o);
        if (table_full_o !== want.full) report_mismatch("table_full", want.full, table_full_o);
        if (pair_count_o !== want.count)
          report_mismatch("pair_count", want.count, pair_count_o);
        if (is_empty_o !== want.empty) report_mismatch("is_empty", want.empty, is_empty_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] key_pool[$];
    logic [31:0] k;
    int unsigned pool_n;

    // Directed part, starting with the reset value of the absent marker.
    push_req(kvt_pkg::MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);
    push_req(kvt_pkg::MODE_REMOVE, 32'h1234_5678, 32'hffff_ffff);
    push_req(kvt_pkg::MODE_ADD, 32'h8000_0000, 32'h7fff_ffff);
    push_req(kvt_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000);
    push_req(kvt_pkg::MODE_ADD, 32'h0000_0000, 32'h0000_0000);
    push_req(kvt_pkg::MODE_ADD, 32'hffff_ffff, 32'hffff_ffff);
    push_req(kvt_pkg::MODE_SEARCH, 32'h8000_0000, 32'h0000_0000);
    push_req(kvt_pkg::MODE_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
    // Keys one bit away from stored ones must miss.
    push_req(kvt_pkg::MODE_SEARCH, 32'h8000_0001, 32'h0000_0000);
    push_req(kvt_pkg::MODE_SEARCH, 32'hffff_fffe, 32'h0000_0000);
    push_req(kvt_pkg::MODE_ADD, 32'h8000_0000, 32'h5555_5555);
    push_req(MODE_UNUSED, 32'h8000_0000, 32'hffff_ffff);
    push_req(MODE_UNUSED, 32'h0000_0001, 32'hffff_ffff);
    push_req(kvt_pkg::MODE_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
    push_req(kvt_pkg::MODE_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
    push_req(kvt_pkg::MODE_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
    push_cfg(32'hdead_beef);
    push_req(kvt_pkg::MODE_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
    push_req(kvt_pkg::MODE_ADD, 32'h5555_5555, 32'haaaa_aaaa);
    push_req(kvt_pkg::MODE_REMOVE, 32'h8000_0000, 32'h0000_0000);
    push_req(kvt_pkg::MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
    push_req(kvt_pkg::MODE_REMOVE, 32'hffff_ffff, 32'h0000_0000);
    push_req(kvt_pkg::MODE_REMOVE, 32'h5555_5555, 32'h0000_0000);
    push_req(kvt_pkg::MODE_SEARCH, 32'h0000_0000, 32'h0000_0000);

    for (int ph = 0; ph < 10; ph++) begin
      no_gaps = (ph == 2 || ph == 6);
      case (ph)
        0: push_cfg(32'h8000_0000);
        1: push_cfg(32'h7fff_ffff);
        2: push_cfg(32'h0000_0000);
        3: push_cfg(32'hffff_ffff);
        default: push_cfg($urandom);
      endcase
      key_pool.delete();
      if (ph % 3 == 1) begin
        // Fill past capacity so new keys get refused, then empty it again.
        for (int i = 0; i < 70; i++) key_pool.push_back($urandom);
        foreach (key_pool[i]) push_req(kvt_pkg::MODE_ADD, key_pool[i], $urandom);
        repeat (20) push_req(pick_mode(), key_pool[$urandom_range(0, 69)], $urandom);
        foreach (key_pool[i]) push_req(kvt_pkg::MODE_REMOVE, key_pool[i], $urandom);
      end else begin
        pool_n = (ph % 3 == 0) ? 8 : 24;
        for (int i = 0; i < pool_n; i++) key_pool.push_back($urandom);
        for (int i = 0; i < 65; i++) begin
          if (i == 30) push_drain();
          if ($urandom_range(0, 9) == 0) k = $urandom;
          else k = key_pool[$urandom_range(0, pool_n - 1)];
          push_req(pick_mode(), k, $urandom);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || start || expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_replies.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_ctrl.sv
rtl/kvt_dp.sv
rtl/key_value_table.sv
tb/key_value_table_tb.sv
